/* sv/eedt_pkg.sv */
package eedt_pkg;

    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH = 256;

    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int STORE_DEPTH = MAX_HEIGHT * MAX_WIDTH;

    localparam int CFG_W = 9;
    localparam int SQ_W = 17;
    localparam int FRAC_W = 8;
    localparam int F_W = $clog2((MAX_HEIGHT - 1) * (MAX_HEIGHT - 1)
                                + (MAX_WIDTH - 1) * (MAX_WIDTH - 1) + 1);
    localparam int XSQ_W = 2 * COL_W;

    localparam int MA_W = F_W + 1;
    localparam int MB_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
    localparam int MP_W = MA_W + MB_W;

    localparam int SQRT_STEPS = (SQ_W + 2 * FRAC_W + 1) / 2;
    localparam int RAD_W = 2 * SQRT_STEPS;
    localparam int ROOT_W = SQRT_STEPS;
    localparam int REM_W = ROOT_W + 3;
    localparam int STEP_W = $clog2(SQRT_STEPS);

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W:0] hcnt_t;
    typedef logic [COL_W:0] cnt_t;
    typedef logic [ROW_W+1:0] run_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SQ_W-1:0] sq_t;
    typedef logic [F_W-1:0] f_t;
    typedef logic [XSQ_W-1:0] xsq_t;
    typedef logic signed [MA_W-1:0] ma_t;
    typedef logic signed [MB_W-1:0] mb_t;
    typedef logic signed [MP_W-1:0] mp_t;
    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [REM_W-1:0] rem_t;
    typedef logic [RAD_W-1:0] rad_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        col_t pos;
        f_t f;
    } ent_t;

    localparam sq_t SQ_EMPTY = '1;

endpackage

/* sv/eedt_ram.sv */
module eedt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/eedt_mul.sv */
module eedt_mul (
    input  logic           aclk,
    input  eedt_pkg::ma_t  a,
    input  eedt_pkg::mb_t  b,
    output eedt_pkg::mp_t  p
);

    eedt_pkg::mp_t prod_reg;
    eedt_pkg::mp_t prod_next;

    assign prod_next = eedt_pkg::mp_t'(a) * eedt_pkg::mp_t'(b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign p = prod_reg;

endmodule

/* sv/eedt_sqrt.sv */
module eedt_sqrt (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  eedt_pkg::sq_t   sq,
    output logic            done,
    output eedt_pkg::root_t root
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    eedt_pkg::step_t step_reg, step_next;
    eedt_pkg::rad_t  rad_reg, rad_next;
    eedt_pkg::rem_t  rem_reg, rem_next;
    eedt_pkg::root_t root_reg, root_next;

    eedt_pkg::rem_t  rem_sh;
    eedt_pkg::rem_t  trial;
    logic            round_up;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        rem_sh = {rem_reg[eedt_pkg::REM_W-3:0], rad_reg[eedt_pkg::RAD_W-1 -: 2]};
        trial = eedt_pkg::rem_t'({root_reg, 2'b01});
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rad_next = eedt_pkg::rad_t'({sq, {(2 * eedt_pkg::FRAC_W){1'b0}}});
            rem_next = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[eedt_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next = rem_sh - trial;
                root_next = {root_reg[eedt_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                root_next = {root_reg[eedt_pkg::ROOT_W-2:0], 1'b0};
            end
            if (step_reg == eedt_pkg::step_t'(eedt_pkg::SQRT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign round_up = (rem_reg > eedt_pkg::rem_t'(root_reg));
    assign done = done_reg;
    assign root = root_reg + {{(eedt_pkg::ROOT_W-1){1'b0}}, round_up};

endmodule

/* sv/exact_euclidean_distance_transform_top.sv */
// Exact Euclidean distance transform. Write image_height (index 0) and image_width (index 1)
// while idle; either write restarts the block. Then send one load beat per pixel in raster
// order (zero marks a feature pixel). After the last pixel, if any feature pixel was seen,
// the block drops s_ready while it runs a column pass and a row pass built on one shared
// registered multiplier, which discards parabolas and then steps along the envelope. Fetch
// beats then return the squared distance and its rounded 9.8 square root in raster order;
// s_ready stays low until each result is issued, and the square root unit yields one result
// bit per cycle. Loads during fetching and fetches during loading are taken and dropped.
// An image with no feature pixel returns saturated values with no_feature set.
module exact_euclidean_distance_transform_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_squared_distance,
    output logic [16:0] m_distance_fixed,
    output logic        m_no_feature,
    output logic        m_last_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd0;
    localparam logic [3:0] REG_IMAGE_WIDTH = 4'd1;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_C_BSTART = 5'd1;
    localparam logic [4:0] S_C_BRD    = 5'd2;
    localparam logic [4:0] S_C_BWR    = 5'd3;
    localparam logic [4:0] S_C_FSTART = 5'd4;
    localparam logic [4:0] S_C_FRD    = 5'd5;
    localparam logic [4:0] S_C_FWR    = 5'd6;
    localparam logic [4:0] S_R_RD     = 5'd7;
    localparam logic [4:0] S_R_VSQ    = 5'd8;
    localparam logic [4:0] S_R_FX     = 5'd9;
    localparam logic [4:0] S_R_TEST0  = 5'd10;
    localparam logic [4:0] S_R_TEST1  = 5'd11;
    localparam logic [4:0] S_R_TEST2  = 5'd12;
    localparam logic [4:0] S_R_POPLD  = 5'd13;
    localparam logic [4:0] S_R_PUSH   = 5'd14;
    localparam logic [4:0] S_R_NEXTX  = 5'd15;
    localparam logic [4:0] S_Q_START  = 5'd16;
    localparam logic [4:0] S_Q_LD0    = 5'd17;
    localparam logic [4:0] S_Q_LD1    = 5'd18;
    localparam logic [4:0] S_Q_TEST   = 5'd19;
    localparam logic [4:0] S_Q_TCMP   = 5'd20;
    localparam logic [4:0] S_Q_ADV    = 5'd21;
    localparam logic [4:0] S_Q_DIST   = 5'd22;
    localparam logic [4:0] S_Q_WR     = 5'd23;
    localparam logic [4:0] S_Q_ROWEND = 5'd24;
    localparam logic [4:0] S_F_SQ     = 5'd25;
    localparam logic [4:0] S_F_WAIT   = 5'd26;
    localparam logic [4:0] S_F_OUT    = 5'd27;

    logic [4:0]          state_reg, state_next;
    logic                phase_reg, phase_next;
    logic                feature_reg, feature_next;
    logic [8:0]          height_reg, height_next;
    logic [8:0]          width_reg, width_next;
    eedt_pkg::row_t      row_reg, row_next;
    eedt_pkg::col_t      col_reg, col_next;
    eedt_pkg::run_t      run_reg, run_next;
    eedt_pkg::xsq_t      xsq_reg, xsq_next;
    eedt_pkg::cnt_t      cnt_reg, cnt_next;
    eedt_pkg::cnt_t      k_reg, k_next;
    logic                m_valid_reg, m_valid_next;

    eedt_pkg::f_t        fx_reg, fx_next;
    eedt_pkg::mp_t       lhs_reg, lhs_next;
    eedt_pkg::ent_t      ea_reg, ea_next;
    eedt_pkg::ent_t      eb_reg, eb_next;
    eedt_pkg::sq_t       sq_hold_reg, sq_hold_next;
    eedt_pkg::root_t     root_hold_reg, root_hold_next;
    eedt_pkg::sq_t       m_sq_reg, m_sq_next;
    eedt_pkg::sq_t       m_dist_reg, m_dist_next;
    logic                m_nf_reg, m_nf_next;
    logic                m_last_reg, m_last_next;

    eedt_pkg::hcnt_t     h_use, w_use;
    eedt_pkg::row_t      hm1;
    eedt_pkg::col_t      wm1;
    eedt_pkg::run_t      two_h, h_run, run_t1;
    logic                last_pos, s_fire;

    logic                store_we;
    eedt_pkg::sq_t       store_wdata, store_rdata;
    eedt_pkg::addr_t     store_addr;
    logic                stk_we;
    eedt_pkg::col_t      stk_waddr, stk_raddr;
    eedt_pkg::ent_t      stk_wdata, stk_rdata;

    eedt_pkg::ma_t       mul_a;
    eedt_pkg::mb_t       mul_b;
    eedt_pkg::mp_t       prod;
    eedt_pkg::mp_t       dist_w;

    logic                sq_start, sq_done;
    eedt_pkg::root_t     sq_root;

    always_comb begin
        if (height_reg == '0) begin
            h_use = eedt_pkg::hcnt_t'(1);
        end else if (32'(height_reg) > 32'(eedt_pkg::MAX_HEIGHT)) begin
            h_use = eedt_pkg::hcnt_t'(eedt_pkg::MAX_HEIGHT);
        end else begin
            h_use = eedt_pkg::hcnt_t'(height_reg);
        end
        if (width_reg == '0) begin
            w_use = eedt_pkg::hcnt_t'(1);
        end else if (32'(width_reg) > 32'(eedt_pkg::MAX_WIDTH)) begin
            w_use = eedt_pkg::hcnt_t'(eedt_pkg::MAX_WIDTH);
        end else begin
            w_use = eedt_pkg::hcnt_t'(width_reg);
        end
    end

    assign hm1 = eedt_pkg::row_t'(h_use - 1'b1);
    assign wm1 = eedt_pkg::col_t'(w_use - 1'b1);
    assign two_h = eedt_pkg::run_t'({h_use, 1'b0});
    assign h_run = eedt_pkg::run_t'(h_use);
    assign run_t1 = (run_reg < two_h) ? run_reg + 1'b1 : run_reg;
    assign last_pos = (row_reg == hm1) && (col_reg == wm1);
    assign s_ready = (state_reg == S_IDLE);
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign store_addr = {row_reg, col_reg};
    assign dist_w = eedt_pkg::mp_t'(ea_reg.f) + eedt_pkg::mp_t'(xsq_reg) - (prod <<< 1);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        feature_next = feature_reg;
        height_next = height_reg;
        width_next = width_reg;
        row_next = row_reg;
        col_next = col_reg;
        run_next = run_reg;
        xsq_next = xsq_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        m_valid_next = m_valid_reg;
        fx_next = fx_reg;
        lhs_next = lhs_reg;
        ea_next = ea_reg;
        eb_next = eb_reg;
        sq_hold_next = sq_hold_reg;
        root_hold_next = root_hold_reg;
        m_sq_next = m_sq_reg;
        m_dist_next = m_dist_reg;
        m_nf_next = m_nf_reg;
        m_last_next = m_last_reg;
        store_we = 1'b0;
        store_wdata = '0;
        stk_we = 1'b0;
        stk_waddr = eedt_pkg::col_t'(cnt_reg);
        stk_wdata = '{pos: col_reg, f: fx_reg};
        stk_raddr = '0;
        mul_a = '0;
        mul_b = '0;
        sq_start = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (!s_op && !phase_reg) begin
                        store_we = 1'b1;
                        store_wdata = eedt_pkg::sq_t'(s_pixel != 8'd0);
                        feature_next = feature_reg | (s_pixel == 8'd0);
                        if (last_pos) begin
                            row_next = '0;
                            col_next = '0;
                            if (feature_next) begin
                                state_next = S_C_BSTART;
                            end else begin
                                phase_next = 1'b1;
                            end
                        end else if (col_reg == wm1) begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end else if (s_op && phase_reg) begin
                        state_next = S_F_SQ;
                    end
                end
            end
            S_C_BSTART: begin
                run_next = two_h;
                row_next = hm1;
                state_next = S_C_BRD;
            end
            S_C_BRD: begin
                state_next = S_C_BWR;
            end
            S_C_BWR: begin
                if (store_rdata == '0) begin
                    run_next = '0;
                end else begin
                    run_next = run_t1;
                end
                store_we = 1'b1;
                store_wdata = eedt_pkg::sq_t'(run_next);
                if (row_reg == '0) begin
                    state_next = S_C_FSTART;
                end else begin
                    row_next = row_reg - 1'b1;
                    state_next = S_C_BRD;
                end
            end
            S_C_FSTART: begin
                run_next = two_h;
                row_next = '0;
                state_next = S_C_FRD;
            end
            S_C_FRD: begin
                state_next = S_C_FWR;
            end
            S_C_FWR: begin
                if (eedt_pkg::sq_t'(run_t1) > store_rdata) begin
                    run_next = eedt_pkg::run_t'(store_rdata);
                end else begin
                    run_next = run_t1;
                end
                store_we = 1'b1;
                store_wdata = (run_next >= h_run) ? eedt_pkg::SQ_EMPTY
                                                  : eedt_pkg::sq_t'(run_next);
                if (row_reg == hm1) begin
                    if (col_reg == wm1) begin
                        row_next = '0;
                        col_next = '0;
                        xsq_next = '0;
                        cnt_next = '0;
                        state_next = S_R_RD;
                    end else begin
                        col_next = col_reg + 1'b1;
                        state_next = S_C_BSTART;
                    end
                end else begin
                    row_next = row_reg + 1'b1;
                    state_next = S_C_FRD;
                end
            end
            S_R_RD: begin
                state_next = S_R_VSQ;
            end
            S_R_VSQ: begin
                if (store_rdata == eedt_pkg::SQ_EMPTY) begin
                    state_next = S_R_NEXTX;
                end else begin
                    mul_a = eedt_pkg::ma_t'(store_rdata);
                    mul_b = eedt_pkg::mb_t'(store_rdata[eedt_pkg::ROW_W-1:0]);
                    state_next = S_R_FX;
                end
            end
            S_R_FX: begin
                fx_next = eedt_pkg::f_t'(prod) + eedt_pkg::f_t'(xsq_reg);
                state_next = S_R_TEST0;
            end
            S_R_TEST0: begin
                if (cnt_reg < eedt_pkg::cnt_t'(2)) begin
                    state_next = S_R_PUSH;
                end else begin
                    mul_a = eedt_pkg::ma_t'(fx_reg) - eedt_pkg::ma_t'(ea_reg.f);
                    mul_b = eedt_pkg::mb_t'(ea_reg.pos) - eedt_pkg::mb_t'(eb_reg.pos);
                    state_next = S_R_TEST1;
                end
            end
            S_R_TEST1: begin
                lhs_next = prod;
                mul_a = eedt_pkg::ma_t'(ea_reg.f) - eedt_pkg::ma_t'(eb_reg.f);
                mul_b = eedt_pkg::mb_t'(col_reg) - eedt_pkg::mb_t'(ea_reg.pos);
                state_next = S_R_TEST2;
            end
            S_R_TEST2: begin
                if (lhs_reg <= prod) begin
                    cnt_next = cnt_reg - 1'b1;
                    ea_next = eb_reg;
                    stk_raddr = eedt_pkg::col_t'(cnt_reg - eedt_pkg::cnt_t'(3));
                    if (cnt_reg >= eedt_pkg::cnt_t'(3)) begin
                        state_next = S_R_POPLD;
                    end else begin
                        state_next = S_R_TEST0;
                    end
                end else begin
                    state_next = S_R_PUSH;
                end
            end
            S_R_POPLD: begin
                eb_next = stk_rdata;
                state_next = S_R_TEST0;
            end
            S_R_PUSH: begin
                stk_we = 1'b1;
                eb_next = ea_reg;
                ea_next = '{pos: col_reg, f: fx_reg};
                cnt_next = cnt_reg + 1'b1;
                state_next = S_R_NEXTX;
            end
            S_R_NEXTX: begin
                if (col_reg == wm1) begin
                    state_next = S_Q_START;
                end else begin
                    xsq_next = xsq_reg + eedt_pkg::xsq_t'({col_reg, 1'b1});
                    col_next = col_reg + 1'b1;
                    state_next = S_R_RD;
                end
            end
            S_Q_START: begin
                stk_raddr = '0;
                col_next = '0;
                xsq_next = '0;
                k_next = '0;
                state_next = S_Q_LD0;
            end
            S_Q_LD0: begin
                ea_next = stk_rdata;
                stk_raddr = eedt_pkg::col_t'(1);
                state_next = S_Q_LD1;
            end
            S_Q_LD1: begin
                eb_next = stk_rdata;
                state_next = S_Q_TEST;
            end
            S_Q_TEST: begin
                if ((k_reg + 1'b1) < cnt_reg) begin
                    mul_a = eedt_pkg::ma_t'(eb_reg.pos) - eedt_pkg::ma_t'(ea_reg.pos);
                    mul_b = eedt_pkg::mb_t'(col_reg);
                    state_next = S_Q_TCMP;
                end else begin
                    state_next = S_Q_DIST;
                end
            end
            S_Q_TCMP: begin
                if (eedt_pkg::mp_t'(eedt_pkg::ma_t'(eb_reg.f) - eedt_pkg::ma_t'(ea_reg.f))
                        < (prod <<< 1)) begin
                    k_next = k_reg + 1'b1;
                    ea_next = eb_reg;
                    stk_raddr = eedt_pkg::col_t'(k_reg + eedt_pkg::cnt_t'(2));
                    state_next = S_Q_ADV;
                end else begin
                    state_next = S_Q_DIST;
                end
            end
            S_Q_ADV: begin
                eb_next = stk_rdata;
                state_next = S_Q_TEST;
            end
            S_Q_DIST: begin
                mul_a = eedt_pkg::ma_t'(col_reg);
                mul_b = eedt_pkg::mb_t'(ea_reg.pos);
                state_next = S_Q_WR;
            end
            S_Q_WR: begin
                store_we = 1'b1;
                store_wdata = eedt_pkg::sq_t'(dist_w);
                if (col_reg == wm1) begin
                    state_next = S_Q_ROWEND;
                end else begin
                    xsq_next = xsq_reg + eedt_pkg::xsq_t'({col_reg, 1'b1});
                    col_next = col_reg + 1'b1;
                    state_next = S_Q_TEST;
                end
            end
            S_Q_ROWEND: begin
                col_next = '0;
                xsq_next = '0;
                cnt_next = '0;
                if (row_reg == hm1) begin
                    row_next = '0;
                    phase_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    row_next = row_reg + 1'b1;
                    state_next = S_R_RD;
                end
            end
            S_F_SQ: begin
                sq_hold_next = store_rdata;
                if (feature_reg) begin
                    sq_start = 1'b1;
                    state_next = S_F_WAIT;
                end else begin
                    state_next = S_F_OUT;
                end
            end
            S_F_WAIT: begin
                if (sq_done) begin
                    root_hold_next = sq_root;
                    state_next = S_F_OUT;
                end
            end
            S_F_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sq_next = feature_reg ? sq_hold_reg : eedt_pkg::SQ_EMPTY;
                    m_dist_next = feature_reg ? eedt_pkg::sq_t'(root_hold_reg)
                                              : eedt_pkg::SQ_EMPTY;
                    m_nf_next = !feature_reg;
                    m_last_next = last_pos;
                    if (last_pos) begin
                        row_next = '0;
                        col_next = '0;
                        phase_next = 1'b0;
                        feature_next = 1'b0;
                    end else if (col_reg == wm1) begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready
                && (cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_IMAGE_WIDTH)) begin
            if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_next = cfg_data;
            end else begin
                width_next = cfg_data;
            end
            state_next = S_IDLE;
            phase_next = 1'b0;
            feature_next = 1'b0;
            row_next = '0;
            col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            feature_reg <= 1'b0;
            height_reg <= 9'd256;
            width_reg <= 9'd256;
            row_reg <= '0;
            col_reg <= '0;
            run_reg <= '0;
            xsq_reg <= '0;
            cnt_reg <= '0;
            k_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            feature_reg <= feature_next;
            height_reg <= height_next;
            width_reg <= width_next;
            row_reg <= row_next;
            col_reg <= col_next;
            run_reg <= run_next;
            xsq_reg <= xsq_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fx_reg <= fx_next;
        lhs_reg <= lhs_next;
        ea_reg <= ea_next;
        eb_reg <= eb_next;
        sq_hold_reg <= sq_hold_next;
        root_hold_reg <= root_hold_next;
        m_sq_reg <= m_sq_next;
        m_dist_reg <= m_dist_next;
        m_nf_reg <= m_nf_next;
        m_last_reg <= m_last_next;
    end

    eedt_ram #(
        .WIDTH(eedt_pkg::SQ_W),
        .DEPTH(eedt_pkg::STORE_DEPTH)
    ) u_store (
        .aclk(aclk),
        .we(store_we),
        .waddr(store_addr),
        .wdata(store_wdata),
        .raddr(store_addr),
        .rdata(store_rdata)
    );

    eedt_ram #(
        .WIDTH($bits(eedt_pkg::ent_t)),
        .DEPTH(eedt_pkg::MAX_WIDTH)
    ) u_stack (
        .aclk(aclk),
        .we(stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    eedt_mul u_mul (
        .aclk(aclk),
        .a(mul_a),
        .b(mul_b),
        .p(prod)
    );

    eedt_sqrt u_sqrt (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(sq_start),
        .sq(sq_hold_next),
        .done(sq_done),
        .root(sq_root)
    );

    assign m_valid = m_valid_reg;
    assign m_squared_distance = m_sq_reg;
    assign m_distance_fixed = m_dist_reg;
    assign m_no_feature = m_nf_reg;
    assign m_last_result = m_last_reg;

endmodule
